// File: rtl/core/one_shot_alarm_table_core_defines.svh
// ----------------------------------------------------------------------------
// One-shot alarm table: assertion macros
// Shared concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ONE_SHOT_ALARM_TABLE_CORE_DEFINES_SVH
`define ONE_SHOT_ALARM_TABLE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// A condition that holds at every clock edge.
`define OSAT_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("one-shot alarm table: assertion failed");
// A consequence that holds in the same cycle as its trigger.
`define OSAT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("one-shot alarm table: assertion failed");
// A consequence that holds in the cycle after its trigger.
`define OSAT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("one-shot alarm table: assertion failed");
`else
`define OSAT_ASSERT(label, expr)
`define OSAT_ASSERT_IMPL(label, ante, cons)
`define OSAT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/core/osat_pkg.sv
// ----------------------------------------------------------------------------
// One-shot alarm table package
// Shared constants, codes and the command record passed from front to back.
// ----------------------------------------------------------------------------
package osat_pkg;

    // Table geometry and clock width.
    localparam int SLOTS_DEFAULT = 64;
    localparam int CLOCK_WIDTH   = 48;
    localparam int MAX_OUT       = 64;

    // Reset value of the cycles-per-tick register.
    localparam logic [15:0] CPT_RESET = 16'd9371;

    // Stream widths.
    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 176;

    // Stored payload: delay, handler, argument, global pointer.
    localparam int PAY_W = 16 + 32 + 32 + 32;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_ARM      = 2'd0,
        OP_RELEASE  = 2'd1,
        OP_SCAN     = 2'd2,
        OP_DISPATCH = 2'd3
    } op_t;

    // Result kinds.
    localparam logic [2:0] KIND_ARM     = 3'd0;
    localparam logic [2:0] KIND_RELEASE = 3'd1;
    localparam logic [2:0] KIND_SCAN    = 3'd2;
    localparam logic [2:0] KIND_FIRED   = 3'd3;
    localparam logic [2:0] KIND_NONE    = 3'd4;

    // Result status codes.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_BAD_ID    = 2'd2;
    localparam logic [1:0] STAT_NOT_ARMED = 2'd3;

    // Decoded command handed from the front to the back.
    typedef struct packed {
        op_t         opcode;
        logic [47:0] now_time;
        logic [15:0] time_ticks;
        logic [31:0] handler_addr;
        logic [31:0] handler_arg;
        logic [31:0] global_ptr;
        logic [7:0]  slot_id;
        logic        rel_bad;
    } cmd_t;

endpackage

// File: rtl/core/osat_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module osat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/osat_front.sv
// ----------------------------------------------------------------------------
// One-shot alarm table front end
// Accepts input beats, checks release ids and queues decoded commands.
// ----------------------------------------------------------------------------
module osat_front #(
    parameter int SLOTS = osat_pkg::SLOTS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [osat_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [1:0]                     s_tuser,
    output logic                           cmd_valid,
    output osat_pkg::cmd_t                 cmd,
    input  logic                           cmd_ready
);

`include "one_shot_alarm_table_core_defines.svh"

    osat_pkg::cmd_t dec;
    osat_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     cnt_reg;
    logic           push, pop;

    // Field split and release id range check.
    always_comb
    begin
        dec.opcode       = osat_pkg::op_t'(s_tuser);
        dec.now_time     = s_tdata[47:0];
        dec.time_ticks   = s_tdata[63:48];
        dec.handler_addr = s_tdata[95:64];
        dec.handler_arg  = s_tdata[127:96];
        dec.global_ptr   = s_tdata[159:128];
        dec.slot_id      = s_tdata[167:160];
        dec.rel_bad      = s_tdata[167] || ({1'b0, s_tdata[167:160]} >= 9'(SLOTS));
    end

    assign s_tready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    // Two-entry command queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                q_reg[wr_ptr_reg] <= dec;
                wr_ptr_reg        <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    `OSAT_ASSERT(a_cnt_bound, cnt_reg <= 2'd2)
    `OSAT_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_reg == $past(cnt_reg) + 2'd1)
    `OSAT_ASSERT_NEXT(a_cnt_down, pop && !push, cnt_reg == $past(cnt_reg) - 2'd1)

endmodule

// File: rtl/core/osat_back.sv
// ----------------------------------------------------------------------------
// One-shot alarm table back end
// Executes queued commands against the alarm table and drives results.
// ----------------------------------------------------------------------------
module osat_back #(
    parameter int SLOTS = osat_pkg::SLOTS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [15:0]                     cfg_wdata,
    input  logic                            cmd_valid,
    input  osat_pkg::cmd_t                  cmd,
    output logic                            cmd_ready,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [osat_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [2:0]                      m_tuser,
    output logic                            m_tlast
);

`include "one_shot_alarm_table_core_defines.svh"

    localparam int IDW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW  = osat_pkg::CLOCK_WIDTH;
    localparam int PW  = osat_pkg::PAY_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARM_ADD,
        ST_SWEEP,
        ST_DISP_RD,
        ST_DISP_OUT,
        ST_EMIT
    } state_t;

    state_t          state_reg;
    osat_pkg::cmd_t  cmd_reg;
    logic [15:0]     cpt_reg;
    logic [31:0]     prod_reg;
    logic [IDW-1:0]  slot_reg;
    logic [SLOTS-1:0] armed_reg, pending_reg;
    logic [CW-1:0]   next_due_reg, min_reg;
    logic            scan_mode_reg, issue_reg, rd_vld_reg;
    logic [IDW-1:0]  addr_reg, rd_idx_reg;
    logic [2:0]      kind_reg;
    logic [1:0]      status_reg;
    logic [5:0]      id_reg;
    logic [6:0]      fire_cnt_reg;
    logic            last_reg;

    // Output register.
    logic            o_valid_reg;
    logic [2:0]      o_kind_reg;
    logic [1:0]      o_status_reg;
    logic [5:0]      o_id_reg;
    logic [PW-1:0]   o_pay_reg;
    logic [CW-1:0]   o_due_reg;
    logic            o_pend_reg, o_last_reg;

    // RAM ports.
    logic [CW-1:0]   due_sum, due_rdata, sweep_min;
    logic [PW-1:0]   pay_wdata, pay_rdata;
    logic            tbl_we, due_re, pay_re;

    logic [SLOTS-1:0] free_vec, pend_clr;
    logic [IDW-1:0]  first_free, first_pend, rel_idx;
    logic            free_any, pend_any, out_free, sweep_hit, o_load;

    // Lowest set bit of a slot vector.
    function automatic logic [IDW-1:0] lowest_set(input logic [SLOTS-1:0] v);
        logic [IDW-1:0] r;
        r = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = IDW'(i);
            end
        end
        return r;
    endfunction

    // Slot selection and table summaries.
    always_comb
    begin
        free_vec   = ~(armed_reg | pending_reg);
        free_any   = |free_vec;
        pend_any   = |pending_reg;
        first_free = lowest_set(free_vec);
        first_pend = lowest_set(pending_reg);
        pend_clr   = pending_reg & ~(SLOTS'(1) << first_pend);
        rel_idx    = cmd.slot_id[IDW-1:0];
        out_free   = !o_valid_reg || m_tready;
        o_load     = ((state_reg == ST_EMIT) || (state_reg == ST_DISP_OUT)) && out_free;
        due_sum    = cmd_reg.now_time + CW'(prod_reg);
        pay_wdata  = {cmd_reg.global_ptr, cmd_reg.handler_arg,
                      cmd_reg.handler_addr, cmd_reg.time_ticks};
        tbl_we     = (state_reg == ST_ARM_ADD);
        due_re     = (state_reg == ST_SWEEP) && issue_reg;
        pay_re     = (state_reg == ST_DISP_RD);
        sweep_hit  = scan_mode_reg && (due_rdata <= cmd_reg.now_time);
        sweep_min  = min_reg;
        if (armed_reg[rd_idx_reg] && !sweep_hit && (due_rdata < min_reg))
        begin
            sweep_min = due_rdata;
        end
    end

    osat_ram #(.WIDTH(CW), .DEPTH(SLOTS)) u_due_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (slot_reg),
        .wdata (due_sum),
        .re    (due_re),
        .raddr (addr_reg),
        .rdata (due_rdata)
    );

    osat_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_pay_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (slot_reg),
        .wdata (pay_wdata),
        .re    (pay_re),
        .raddr (first_pend),
        .rdata (pay_rdata)
    );

    assign cmd_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = o_valid_reg;
    assign m_tuser   = o_kind_reg;
    assign m_tlast   = o_last_reg;
    assign m_tdata   = {7'd0, o_pend_reg, o_due_reg, o_pay_reg, o_id_reg, o_status_reg};

    // Sequencer, table flags and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= '0;
            cpt_reg       <= osat_pkg::CPT_RESET;
            prod_reg      <= '0;
            slot_reg      <= '0;
            armed_reg     <= '0;
            pending_reg   <= '0;
            next_due_reg  <= '1;
            min_reg       <= '1;
            scan_mode_reg <= 1'b0;
            issue_reg     <= 1'b0;
            rd_vld_reg    <= 1'b0;
            addr_reg      <= '0;
            rd_idx_reg    <= '0;
            kind_reg      <= osat_pkg::KIND_ARM;
            status_reg    <= osat_pkg::STAT_OK;
            id_reg        <= '0;
            fire_cnt_reg  <= '0;
            last_reg      <= 1'b0;
            o_valid_reg   <= 1'b0;
            o_kind_reg    <= osat_pkg::KIND_ARM;
            o_status_reg  <= osat_pkg::STAT_OK;
            o_id_reg      <= '0;
            o_pay_reg     <= '0;
            o_due_reg     <= '0;
            o_pend_reg    <= 1'b0;
            o_last_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cpt_reg <= cfg_wdata;
            end
            if (o_valid_reg && m_tready && !o_load)
            begin
                o_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg    <= cmd;
                        id_reg     <= '0;
                        status_reg <= osat_pkg::STAT_OK;
                        unique case (cmd.opcode)
                            osat_pkg::OP_ARM:
                            begin
                                kind_reg <= osat_pkg::KIND_ARM;
                                if (free_any)
                                begin
                                    slot_reg  <= first_free;
                                    prod_reg  <= 32'(cmd.time_ticks) * 32'(cpt_reg);
                                    state_reg <= ST_ARM_ADD;
                                end
                                else
                                begin
                                    status_reg <= osat_pkg::STAT_FULL;
                                    state_reg  <= ST_EMIT;
                                end
                            end
                            osat_pkg::OP_RELEASE:
                            begin
                                kind_reg <= osat_pkg::KIND_RELEASE;
                                if (cmd.rel_bad)
                                begin
                                    status_reg <= osat_pkg::STAT_BAD_ID;
                                    state_reg  <= ST_EMIT;
                                end
                                else if (!armed_reg[rel_idx] && !pending_reg[rel_idx])
                                begin
                                    status_reg <= osat_pkg::STAT_NOT_ARMED;
                                    state_reg  <= ST_EMIT;
                                end
                                else
                                begin
                                    armed_reg[rel_idx]   <= 1'b0;
                                    pending_reg[rel_idx] <= 1'b0;
                                    id_reg               <= 6'(rel_idx);
                                    if (armed_reg[rel_idx])
                                    begin
                                        // Earliest due time must be recomputed.
                                        scan_mode_reg <= 1'b0;
                                        addr_reg      <= '0;
                                        issue_reg     <= 1'b1;
                                        rd_vld_reg    <= 1'b0;
                                        min_reg       <= '1;
                                        state_reg     <= ST_SWEEP;
                                    end
                                    else
                                    begin
                                        state_reg <= ST_EMIT;
                                    end
                                end
                            end
                            osat_pkg::OP_SCAN:
                            begin
                                kind_reg      <= osat_pkg::KIND_SCAN;
                                scan_mode_reg <= 1'b1;
                                addr_reg      <= '0;
                                issue_reg     <= 1'b1;
                                rd_vld_reg    <= 1'b0;
                                min_reg       <= '1;
                                state_reg     <= ST_SWEEP;
                            end
                            osat_pkg::OP_DISPATCH:
                            begin
                                fire_cnt_reg <= '0;
                                kind_reg     <= osat_pkg::KIND_NONE;
                                if (pend_any)
                                begin
                                    state_reg <= ST_DISP_RD;
                                end
                                else
                                begin
                                    state_reg <= ST_EMIT;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end

                // Store the new alarm and fold its due time into the minimum.
                ST_ARM_ADD:
                begin
                    armed_reg[slot_reg] <= 1'b1;
                    if (due_sum < next_due_reg)
                    begin
                        next_due_reg <= due_sum;
                    end
                    id_reg    <= 6'(slot_reg);
                    state_reg <= ST_EMIT;
                end

                // Walk all due times: in a scan, promote expired ones; track the minimum.
                ST_SWEEP:
                begin
                    rd_vld_reg <= issue_reg;
                    rd_idx_reg <= addr_reg;
                    if (issue_reg)
                    begin
                        if (addr_reg == IDW'(SLOTS - 1))
                        begin
                            issue_reg <= 1'b0;
                        end
                        else
                        begin
                            addr_reg <= addr_reg + 1'b1;
                        end
                    end
                    if (rd_vld_reg)
                    begin
                        min_reg <= sweep_min;
                        if (armed_reg[rd_idx_reg] && sweep_hit)
                        begin
                            armed_reg[rd_idx_reg]   <= 1'b0;
                            pending_reg[rd_idx_reg] <= 1'b1;
                        end
                        if (rd_idx_reg == IDW'(SLOTS - 1))
                        begin
                            next_due_reg <= sweep_min;
                            state_reg    <= ST_EMIT;
                        end
                    end
                end

                // Pick the lowest pending alarm and fetch its payload.
                ST_DISP_RD:
                begin
                    pending_reg[first_pend] <= 1'b0;
                    armed_reg[first_pend]   <= 1'b0;
                    id_reg       <= 6'(first_pend);
                    last_reg     <= (pend_clr == '0) ||
                                    (fire_cnt_reg == 7'(osat_pkg::MAX_OUT - 1));
                    fire_cnt_reg <= fire_cnt_reg + 7'd1;
                    state_reg    <= ST_DISP_OUT;
                end

                ST_DISP_OUT:
                begin
                    if (out_free)
                    begin
                        o_valid_reg  <= 1'b1;
                        o_kind_reg   <= osat_pkg::KIND_FIRED;
                        o_status_reg <= osat_pkg::STAT_OK;
                        o_id_reg     <= id_reg;
                        o_pay_reg    <= pay_rdata;
                        o_due_reg    <= next_due_reg;
                        o_pend_reg   <= pend_any;
                        o_last_reg   <= last_reg;
                        state_reg    <= last_reg ? ST_IDLE : ST_DISP_RD;
                    end
                end

                // Single reply beat.
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        o_valid_reg  <= 1'b1;
                        o_kind_reg   <= kind_reg;
                        o_status_reg <= status_reg;
                        o_id_reg     <= id_reg;
                        o_pay_reg    <= '0;
                        o_due_reg    <= next_due_reg;
                        o_pend_reg   <= pend_any;
                        o_last_reg   <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `OSAT_ASSERT(a_flags_disjoint, (armed_reg & pending_reg) == '0)
    `OSAT_ASSERT(a_fire_bound, fire_cnt_reg <= 7'(osat_pkg::MAX_OUT))
    `OSAT_ASSERT_NEXT(a_emit_last, (state_reg == ST_EMIT) && out_free,
                      o_valid_reg && o_last_reg && (state_reg == ST_IDLE))

endmodule

// File: rtl/core/one_shot_alarm_table_core.sv
// ----------------------------------------------------------------------------
// One-shot alarm table core
// Top level: command front end, queue and table back end.
// ----------------------------------------------------------------------------
// Each input beat is one command; one command is handled at a time. An arm
// stores the alarm, then emits its output beat. A release of a pending slot
// goes straight to its reply; a release of an armed slot and a due scan walk
// the due-time memory at one entry per cycle to recompute the earliest due
// time. A dispatch emits fired alarms one at a time (pick and payload memory
// read, then the output beat, which waits for the output), at most 64 per
// command. A two-entry command queue lets the input side run ahead, and a
// result register holds each output beat until taken. The user must write
// the cycles_per_tick register only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module one_shot_alarm_table_core #(
    parameter int SLOTS = osat_pkg::SLOTS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [15:0]                     cfg_wdata,  // cycles_per_tick
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // now_time, time_ticks, handler_addr, handler_arg, global_ptr, slot_id
    input  logic [osat_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]                      s_tuser,    // opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status, alarm_id, fired_ticks, fired_handler, fired_arg, fired_gp,
    // next_due, any_pending, zero fill
    output logic [osat_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [2:0]                      m_tuser,    // kind
    output logic                            m_tlast     // last_of_run
);

    osat_pkg::cmd_t cmd;
    logic           cmd_valid, cmd_ready;

    osat_front #(.SLOTS(SLOTS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    osat_back #(.SLOTS(SLOTS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
